/* rtl/core/spc_pkg.sv */
`timescale 1ns / 1ps

package spc_pkg;

  localparam int POS_W       = 32;
  localparam int DELAY_W     = 10;
  localparam int CALIB_W     = 3;
  localparam int COIL_W      = 4;
  localparam int SLOT_W      = 7;   // magnitude bits of the signed slot field

  localparam logic [DELAY_W-1:0] ELAPSED_TOP = {DELAY_W{1'b1}};
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(2);
  localparam logic [CALIB_W-1:0] CALIB_ALL   = {CALIB_W{1'b1}};

  localparam int NUM_SLOTS    = 8;
  localparam int SLOT_HALF    = NUM_SLOTS / 2;
  localparam int SLOT_SPAN_RW = NUM_SLOTS - 1 - SLOT_HALF;
  // upper span is empty for two slots; keep a harmless divisor there
  localparam int SLOT_SPAN    = (SLOT_SPAN_RW < 1) ? 1 : SLOT_SPAN_RW;

  // slot offset width; the lower span is never the smaller one
  localparam int DIV_W = $clog2(SLOT_HALF + 1);

  // rounded-up reciprocals of the two spans, scaled by 2^SHIFT
  localparam int LO_SHIFT = POS_W + $clog2(SLOT_HALF);
  localparam int HI_SHIFT = POS_W + $clog2(SLOT_SPAN);
  localparam int RECIP_W  = POS_W + 2;
  localparam logic [RECIP_W-1:0] LO_RECIP =
    RECIP_W'((64'd1 << LO_SHIFT) / SLOT_HALF + 1);
  localparam logic [RECIP_W-1:0] HI_RECIP =
    RECIP_W'((64'd1 << HI_SHIFT) / SLOT_SPAN + 1);
  localparam int PROD_W = (LO_SHIFT + POS_W > POS_W + RECIP_W + 1) ?
                          (LO_SHIFT + POS_W) : (POS_W + RECIP_W + 1);

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_INIT    = 3'd1,
    CMD_TARGET  = 3'd2,
    CMD_JOG     = 3'd3,
    CMD_CAL_L   = 3'd4,
    CMD_CAL_C   = 3'd5,
    CMD_CAL_R   = 3'd6,
    CMD_GOTO    = 3'd7
  } cmd_e;

  // half-step coil sequence, bit0 = IN1
  function automatic logic [COIL_W-1:0] half_step(input logic [2:0] idx);
    logic [COIL_W-1:0] c;
    case (idx)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/stepper_position_controller.sv */
`timescale 1ns / 1ps

// Channel | Dir | Handshake               | Payload
// --------+-----+-------------------------+------------------------------------------
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (step_delay_ms)
// in      | in  | in_valid_i/in_ready_o   | cmd_i, target_pos_i, jog_delta_i,
//         |     |                         | slot_index_i
// out     | out | out_valid_o/out_ready_i | coils_o, position_o, busy_res_o,
//         |     |                         | calib_mask_o, calibrated_o, stepped_o
//
// One request per cycle while the output is not stalled: a request is held in
// the input register and evaluated there, and its result is registered in the
// output register, from which it can be taken.
// Go-to-slot is done in the same single pass (multiply, reciprocal divide).
// Reset clears all positions, flags, the delay (to 2) and both valids.
// A stalled output holds the input register, which then holds off new requests.
module stepper_position_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spc_pkg::DELAY_W-1:0]   cfg_data_i,
  // requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    cmd_i,
  input  logic signed [31:0]            target_pos_i,
  input  logic signed [15:0]            jog_delta_i,
  input  logic signed [7:0]             slot_index_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spc_pkg::COIL_W-1:0]    coils_o,
  output logic signed [31:0]            position_o,
  output logic                          busy_res_o,
  output logic [spc_pkg::CALIB_W-1:0]   calib_mask_o,
  output logic                          calibrated_o,
  output logic                          stepped_o
);
  import spc_pkg::*;

  // input register
  logic              in_valid_q;
  logic [2:0]        cmd_q;
  logic [POS_W-1:0]  tgt_q;
  logic [15:0]       jog_q;
  logic [7:0]        slot_q;

  // controller state
  logic [DELAY_W-1:0] delay_q;
  logic [POS_W-1:0]   cur_q, cur_d;
  logic [POS_W-1:0]   goal_q, goal_d;
  logic [DELAY_W-1:0] elap_q, elap_d;
  logic [COIL_W-1:0]  coil_q, coil_d;
  logic [CALIB_W-1:0] cal_q, cal_d;
  logic [POS_W-1:0]   left_q, left_d;
  logic [POS_W-1:0]   ctr_q, ctr_d;
  logic [POS_W-1:0]   right_q, right_d;
  logic               stepped_d;

  // result register
  logic               out_valid_q;
  logic [COIL_W-1:0]  coils_q;
  logic [POS_W-1:0]   pos_q;
  logic               busy_q;
  logic [CALIB_W-1:0] mask_q;
  logic               stepped_q;

  logic res_free;
  logic advance;
  logic goto_go;

  // interpolation
  logic [SLOT_W-1:0] slot_c;
  logic              use_lo;
  logic [DIV_W-1:0]  slot_k;
  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  prod;
  logic [POS_W-1:0]  quot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (cfg_valid_i) begin
      delay_q <= cfg_data_i;
    end
  end

  assign res_free   = !out_valid_q || out_ready_i;
  assign goto_go    = in_valid_q && (cmd_e'(cmd_q) == CMD_GOTO) &&
                      (cal_q == CALIB_ALL) && !slot_q[7];
  assign advance    = in_valid_q && res_free;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q  <= cmd_i;
      tgt_q  <= target_pos_i;
      jog_q  <= jog_delta_i;
      slot_q <= slot_index_i;
    end
  end

  // slot clamp and choice of segment; a negative slot is rejected by goto_go
  always_comb begin
    slot_c = slot_q[SLOT_W-1:0];
    if (slot_c >= SLOT_W'(NUM_SLOTS)) begin
      slot_c = SLOT_W'(NUM_SLOTS - 1);
    end
    use_lo = (slot_c <= SLOT_W'(SLOT_HALF));
    slot_k = use_lo ? DIV_W'(slot_c) : DIV_W'(slot_c - SLOT_W'(SLOT_HALF));
    base   = use_lo ? left_q : ctr_q;
    prod   = POS_W'((use_lo ? (ctr_q - left_q) : (right_q - ctr_q)) * POS_W'(slot_k));
  end

  spc_div u_div (
    .upper_i    (!use_lo),
    .dividend_i (prod),
    .quotient_o (quot)
  );

  // next state for the request in the input register
  always_comb begin
    logic [DELAY_W-1:0] e;
    cur_d     = cur_q;
    goal_d    = goal_q;
    elap_d    = elap_q;
    coil_d    = coil_q;
    cal_d     = cal_q;
    left_d    = left_q;
    ctr_d     = ctr_q;
    right_d   = right_q;
    stepped_d = 1'b0;
    e         = (elap_q < ELAPSED_TOP) ? (elap_q + DELAY_W'(1)) : elap_q;
    case (cmd_e'(cmd_q))
      CMD_TICK: begin
        elap_d = e;
        if ((cur_q != goal_q) && (e >= delay_q)) begin
          elap_d    = '0;
          cur_d     = ($signed(cur_q) < $signed(goal_q)) ? (cur_q + POS_W'(1))
                                                         : (cur_q - POS_W'(1));
          coil_d    = half_step(cur_d[2:0]);
          stepped_d = 1'b1;
        end
      end
      CMD_INIT: begin
        cur_d  = '0;
        goal_d = '0;
        cal_d  = '0;
        coil_d = '0;
      end
      CMD_TARGET: begin
        goal_d = tgt_q;
      end
      CMD_JOG: begin
        goal_d = goal_q + {{(POS_W-16){jog_q[15]}}, jog_q};
      end
      CMD_CAL_L: begin
        left_d = cur_q;
        cal_d  = cal_q | 3'b001;
      end
      CMD_CAL_C: begin
        ctr_d = cur_q;
        cal_d = cal_q | 3'b010;
      end
      CMD_CAL_R: begin
        right_d = cur_q;
        cal_d   = cal_q | 3'b100;
      end
      CMD_GOTO: begin
        if (goto_go) begin
          goal_d = base + quot;
        end
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      goal_q  <= '0;
      elap_q  <= '0;
      coil_q  <= '0;
      cal_q   <= '0;
      left_q  <= '0;
      ctr_q   <= '0;
      right_q <= '0;
    end else if (advance) begin
      cur_q   <= cur_d;
      goal_q  <= goal_d;
      elap_q  <= elap_d;
      coil_q  <= coil_d;
      cal_q   <= cal_d;
      left_q  <= left_d;
      ctr_q   <= ctr_d;
      right_q <= right_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      coils_q   <= coil_d;
      pos_q     <= cur_d;
      busy_q    <= (cur_d != goal_d);
      mask_q    <= cal_d;
      stepped_q <= stepped_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign coils_o      = coils_q;
  assign position_o   = pos_q;
  assign busy_res_o   = busy_q;
  assign calib_mask_o = mask_q;
  assign calibrated_o = (mask_q == CALIB_ALL);
  assign stepped_o    = stepped_q;

endmodule

/* rtl/core/spc_div.sv */
`timescale 1ns / 1ps

// Signed divide by the span of the chosen segment, truncating toward zero.
// Multiplies by a rounded-up reciprocal; a negative dividend gets one added
// back to turn the floor into truncation. Exact for every 32-bit dividend.
module spc_div (
  input  logic                        upper_i,
  input  logic [spc_pkg::POS_W-1:0]   dividend_i,
  output logic [spc_pkg::POS_W-1:0]   quotient_o
);
  import spc_pkg::*;

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [POS_W-1:0]   quot_lo;
  logic [POS_W-1:0]   quot_hi;

  assign recip      = upper_i ? HI_RECIP : LO_RECIP;
  assign prod       = PROD_W'($signed(dividend_i)) * PROD_W'($signed({1'b0, recip}));
  assign quot_lo    = prod[LO_SHIFT +: POS_W];
  assign quot_hi    = prod[HI_SHIFT +: POS_W];
  assign quotient_o = (upper_i ? quot_hi : quot_lo) + POS_W'(dividend_i[POS_W-1]);

endmodule

/* verif/tb_stepper_position_controller.sv */
`timescale 1ns / 1ps

// Stand-alone bench for the stepper position controller.
// Requests go in over a valid/ready channel and each produces one status result.
// A predictor in this file tracks the motor state and queues the status that
// each accepted request should produce. The checker pops that queue on every
// accepted result.
module tb_stepper_position_controller;
  import spc_pkg::*;

  // half-step coil drive, nibble n is the drive for position[2:0] == n
  localparam logic [31:0] COIL_SEQ  = 32'h9_8_C_4_6_2_3_1;
  localparam int          UPPER_DIV = NUM_SLOTS - 1 - SLOT_HALF;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic [31:0]        position;
    logic               busy;
    logic [CALIB_W-1:0] mask;
    logic               calibrated;
    logic               stepped;
  } motor_status_t;

  // ---------------------------------------------------------------- DUT I/O
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [DELAY_W-1:0] cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  cmd_e               cmd_i        = CMD_TICK;
  logic [31:0]        target_pos_i = '0;
  logic [15:0]        jog_delta_i  = '0;
  logic [7:0]         slot_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [COIL_W-1:0]  coils_o;
  logic [31:0]        position_o;
  logic               busy_res_o;
  logic [CALIB_W-1:0] calib_mask_o;
  logic               calibrated_o;
  logic               stepped_o;

  stepper_position_controller uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .target_pos_i (target_pos_i),
    .jog_delta_i  (jog_delta_i),
    .slot_index_i (slot_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coils_o      (coils_o),
    .position_o   (position_o),
    .busy_res_o   (busy_res_o),
    .calib_mask_o (calib_mask_o),
    .calibrated_o (calibrated_o),
    .stepped_o    (stepped_o)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------- predicted motor
  logic [31:0]        cur_pos, goal_pos, left_pos, centre_pos, right_pos;
  logic [DELAY_W-1:0] elapsed_ms, step_delay;
  logic [COIL_W-1:0]  coil_state;
  logic [CALIB_W-1:0] calib_bits;

  motor_status_t motor_status_q[$];
  int            mismatch_count = 0;

  // idling controls; each percentage is the chance of an idle cycle
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;   // set by a test, taken over by the receiver
  int rx_hold_left = 0;

  initial begin
    cur_pos    = '0;
    goal_pos   = '0;
    left_pos   = '0;
    centre_pos = '0;
    right_pos  = '0;
    elapsed_ms = '0;
    step_delay = DELAY_RESET;
    coil_state = '0;
    calib_bits = '0;
  end

  // lo + (hi - lo) * k / d, difference and product wrap, division truncates
  function automatic logic [31:0] lerp_slot(input logic [31:0] lo, input logic [31:0] hi,
                                            input int k, input int d);
    int prod;
    int quot;
    prod = int'(hi - lo) * k;
    quot = prod / d;
    return lo + 32'(quot);
  endfunction

  task automatic advance_motor_model(input cmd_e cmd, input logic [31:0] tpos,
                                     input logic [15:0] jdelta, input logic [7:0] slot);
    motor_status_t st;
    int            sidx;
    logic          moved;
    moved = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (elapsed_ms != ELAPSED_TOP) elapsed_ms = elapsed_ms + 1'b1;
        if (cur_pos != goal_pos && elapsed_ms >= step_delay) begin
          elapsed_ms = '0;
          if ($signed(cur_pos) < $signed(goal_pos)) cur_pos = cur_pos + 1;
          else cur_pos = cur_pos - 1;
          coil_state = COIL_SEQ[4*cur_pos[2:0] +: 4];
          moved      = 1'b1;
        end
      end
      CMD_INIT: begin
        cur_pos    = '0;
        goal_pos   = '0;
        calib_bits = '0;
        coil_state = '0;
      end
      CMD_TARGET: goal_pos = tpos;
      CMD_JOG:    goal_pos = goal_pos + {{16{jdelta[15]}}, jdelta};
      CMD_CAL_L: begin
        left_pos   = cur_pos;
        calib_bits = calib_bits | 3'b001;
      end
      CMD_CAL_C: begin
        centre_pos = cur_pos;
        calib_bits = calib_bits | 3'b010;
      end
      CMD_CAL_R: begin
        right_pos  = cur_pos;
        calib_bits = calib_bits | 3'b100;
      end
      default: begin
        sidx = int'($signed(slot));
        if (calib_bits == CALIB_ALL && sidx >= 0) begin
          if (sidx >= NUM_SLOTS) sidx = NUM_SLOTS - 1;
          if (sidx <= SLOT_HALF) goal_pos = lerp_slot(left_pos, centre_pos, sidx, SLOT_HALF);
          else goal_pos = lerp_slot(centre_pos, right_pos, sidx - SLOT_HALF, UPPER_DIV);
        end
      end
    endcase
    st.coils      = coil_state;
    st.position   = cur_pos;
    st.busy       = (cur_pos != goal_pos);
    st.mask       = calib_bits;
    st.calibrated = (calib_bits == CALIB_ALL);
    st.stepped    = moved;
    motor_status_q.push_back(st);
  endtask

  // ------------------------------------------------------- request driving
  // valid is left high after acceptance; the next request either follows in
  // the same step or an idle cycle lowers it first
  task automatic send_request(input cmd_e cmd, input logic [31:0] tpos,
                              input logic [15:0] jdelta, input logic [7:0] slot);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    target_pos_i <= tpos;
    jog_delta_i  <= jdelta;
    slot_index_i <= slot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_motor_model(cmd, tpos, jdelta, slot);
  endtask

  // argument lands in the field the command reads, the rest is noise
  task automatic issue(input cmd_e cmd, input logic [31:0] arg);
    logic [31:0] tpos;
    logic [15:0] jdelta;
    logic [7:0]  slot;
    tpos   = $urandom;
    jdelta = 16'($urandom);
    slot   = 8'($urandom);
    case (cmd)
      CMD_TARGET: tpos   = arg;
      CMD_JOG:    jdelta = arg[15:0];
      CMD_GOTO:   slot   = arg[7:0];
      default:    ;
    endcase
    send_request(cmd, tpos, jdelta, slot);
  endtask

  // drop valid and wait out every queued status, then a short quiet gap
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (motor_status_q.size() != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  task automatic write_step_delay(input logic [DELAY_W-1:0] delay);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= delay;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    step_delay = delay;
  endtask

  // ------------------------------------------------------- result side
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic string status_text(input motor_status_t s);
    return $sformatf("coils=%h pos=%h busy=%b mask=%b cal=%b step=%b",
                     s.coils, s.position, s.busy, s.mask, s.calibrated, s.stepped);
  endfunction

  task automatic report_fault(input string msg);
    if (mismatch_count < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  motor_status_t seen_status, want_status;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_status = '{coils_o, position_o, busy_res_o, calib_mask_o, calibrated_o, stepped_o};
      if (motor_status_q.size() == 0) begin
        report_fault({"result with nothing pending: ", status_text(seen_status)});
      end else begin
        want_status = motor_status_q.pop_front();
        if (seen_status !== want_status)
          report_fault({"exp ", status_text(want_status), " got ", status_text(seen_status)});
      end
    end
  end

  // ------------------------------------------------------- tests
  task automatic test_power_on_state();
    issue(CMD_TICK, '0);
    issue(CMD_GOTO, 32'd3);       // not calibrated, ignored
    issue(CMD_JOG, '0);
    issue(CMD_TICK, '0);
  endtask

  // goal wraps through the jog; init pulls it back to zero
  task automatic test_target_extremes();
    issue(CMD_TARGET, 32'h7FFF_FFFF);
    issue(CMD_JOG, 32'h0000_7FFF);
    issue(CMD_TARGET, 32'h8000_0000);
    issue(CMD_JOG, 32'h0000_8000);
    issue(CMD_TICK, '0);
    issue(CMD_INIT, '0);
  endtask

  // every coil pattern both ways, then settle on the target
  task automatic test_half_step_walk();
    issue(CMD_TARGET, 32'd9);
    repeat (11) issue(CMD_TICK, '0);
    issue(CMD_TARGET, -32'sd2);
    repeat (12) issue(CMD_TICK, '0);
  endtask

  // left above centre gives a negative span; truncation goes toward zero
  task automatic test_calibrated_slots();
    issue(CMD_TARGET, 32'd6);
    repeat (8) issue(CMD_TICK, '0);
    issue(CMD_CAL_L, '0);
    issue(CMD_TARGET, -32'sd3);
    repeat (9) issue(CMD_TICK, '0);
    issue(CMD_CAL_C, '0);
    issue(CMD_TARGET, 32'd9);
    repeat (12) issue(CMD_TICK, '0);
    issue(CMD_CAL_R, '0);
    for (int s = 0; s < NUM_SLOTS; s++) issue(CMD_GOTO, 32'(s));
    issue(CMD_GOTO, 32'd127);     // clamped to the last slot
    issue(CMD_GOTO, 32'hFF);      // negative, ignored
    issue(CMD_GOTO, 32'h80);
    issue(CMD_INIT, '0);
    issue(CMD_GOTO, 32'd2);       // flags cleared, ignored
    issue(CMD_TICK, '0);
  endtask

  // idle ticks pin the ms counter at its top, so a slow delay steps at once
  task automatic test_elapsed_saturation();
    issue(CMD_TARGET, cur_pos);
    repeat (1030) issue(CMD_TICK, '0);
    issue(CMD_TARGET, cur_pos + 1);
    repeat (3) issue(CMD_TICK, '0);
    issue(CMD_TARGET, cur_pos - 1);
    issue(CMD_TICK, '0);
  endtask

  // mostly ticks and nearby targets so the motor keeps moving and the
  // calibration fills; jogs, go-to-slot, init and some full-range targets mix in
  task automatic random_request();
    int          pick;
    cmd_e        cmd;
    logic [31:0] tpos;
    logic [15:0] jdelta;
    logic [7:0]  slot;
    pick   = $urandom_range(0, 99);
    tpos   = $urandom;
    jdelta = 16'($urandom);
    slot   = 8'($urandom);
    if (pick < 50) begin
      cmd = CMD_TICK;
    end else if (pick < 60) begin
      cmd  = CMD_TARGET;
      tpos = cur_pos + 32'($urandom_range(0, 40)) - 32'd20;
    end else if (pick < 63) begin
      cmd = CMD_TARGET;
    end else if (pick < 69) begin
      cmd = CMD_JOG;
      if ($urandom_range(0, 4) != 0) jdelta = 16'($urandom_range(0, 32)) - 16'd16;
    end else if (pick < 73) begin
      cmd = CMD_CAL_L;
    end else if (pick < 77) begin
      cmd = CMD_CAL_C;
    end else if (pick < 81) begin
      cmd = CMD_CAL_R;
    end else if (pick < 95) begin
      cmd = CMD_GOTO;
      if ($urandom_range(0, 99) < 70) slot = 8'($urandom_range(0, NUM_SLOTS + 1));
    end else begin
      cmd = CMD_INIT;
    end
    send_request(cmd, tpos, jdelta, slot);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) random_request();
  endtask

  // receiver stalls long enough for the block to fill and stop taking input
  task automatic test_output_backpressure();
    wait_for_results();
    rx_hold_req = 300;
    repeat (40) random_request();
    wait_for_results();
  endtask

  // ------------------------------------------------------- sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 16;
    rx_idle_pct = 69;
    test_power_on_state();
    test_target_extremes();
    write_step_delay('0);
    test_half_step_walk();
    test_calibrated_slots();
    write_step_delay(10'd1);
    test_random_mix(200);

    wait_for_results();
    tx_idle_pct = 69;
    rx_idle_pct = 16;
    test_output_backpressure();
    write_step_delay(DELAY_W'($urandom_range(0, 4)));
    test_random_mix(180);

    wait_for_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_step_delay(ELAPSED_TOP);
    test_elapsed_saturation();
    write_step_delay(10'd3);
    test_random_mix(140);
    write_step_delay(DELAY_RESET);
    test_random_mix(20);

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
